>>> rtl/acu_pkg.sv
// ----------------------------------------------------------------------------
// acu_pkg
// Shared types, constants and exponential tables for the activation unit.
// ----------------------------------------------------------------------------
package acu_pkg;

   localparam int FRAC_BITS  = 12;
   localparam int Q_BITS     = 47;
   localparam int TAB_W      = Q_BITS + 1;
   localparam int DIV_BITS   = FRAC_BITS + 2;
   localparam int FRONT_STG  = 3;
   localparam int EXP_STG    = 2;
   localparam int PIPE_DEPTH = FRONT_STG + EXP_STG + DIV_BITS + 1;
   localparam int GRAD_SHIFT = 2 * FRAC_BITS;

   localparam logic [TAB_W-1:0] Q_ONE    = TAB_W'(1) << Q_BITS;
   localparam logic [47:0]      GRAD_RND = 48'(1) << (GRAD_SHIFT - 1);
   localparam logic signed [16:0] FX_ONE = 17'sd1 <<< FRAC_BITS;
   localparam logic signed [33:0] FX_ONE_SQ = 34'sd1 <<< GRAD_SHIFT;

   typedef enum logic [1:0] {
      MODE_LINEAR  = 2'd0,
      MODE_SIGMOID = 2'd1,
      MODE_RELU    = 2'd2,
      MODE_TANH    = 2'd3
   } acti_mode_type;

   typedef struct packed {
      logic               grad;
      logic signed [15:0] x;
      logic signed [15:0] d;
      logic               last;
   } item_type;

   typedef struct packed {
      logic               grad;
      acti_mode_type      mode;
      logic signed [15:0] x;
      logic               last;
   } tag_type;

   typedef struct packed {
      tag_type            tag;
      logic signed [15:0] gres;
      logic [TAB_W-1:0]   t0;
      logic [TAB_W-1:0]   p1;
   } prod_type;

   typedef struct packed {
      tag_type            tag;
      logic signed [15:0] gres;
      logic [TAB_W:0]     num;
      logic [TAB_W:0]     den;
   } frac_type;

   localparam logic [63:0] ONE60 = 64'(1) << 60;

   function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'b0, a} * {64'b0, b};
      return p[123:60];
   endfunction

   function automatic logic [63:0] exp_small(input logic [63:0] f);
      logic [63:0] t;
      logic [63:0] pos;
      logic [63:0] neg;
      t   = f;
      neg = t;
      t   = mul_q60(t, f) / 64'd2;
      pos = ONE60 + t;
      t   = mul_q60(t, f) / 64'd3;
      neg = neg + t;
      t   = mul_q60(t, f) / 64'd4;
      pos = pos + t;
      t   = mul_q60(t, f) / 64'd5;
      neg = neg + t;
      t   = mul_q60(t, f) / 64'd6;
      pos = pos + t;
      t   = mul_q60(t, f) / 64'd7;
      neg = neg + t;
      t   = mul_q60(t, f) / 64'd8;
      pos = pos + t;
      t   = mul_q60(t, f) / 64'd9;
      neg = neg + t;
      return pos - neg;
   endfunction

   function automatic logic [TAB_W-1:0] to_q47(input logic [63:0] v);
      logic [63:0] r;
      r = (v + (64'(1) << (59 - Q_BITS))) >> (60 - Q_BITS);
      return r[TAB_W-1:0];
   endfunction

   // e^-(k / 4096)
   function automatic logic [63:0][TAB_W-1:0] build_near();
      logic [63:0][TAB_W-1:0] tab;
      for (int k = 0; k < 64; k++) begin
         tab[k] = to_q47(exp_small(64'(k) << 48));
      end
      return tab;
   endfunction

   // e^-(k / 64)
   function automatic logic [63:0][TAB_W-1:0] build_mid();
      logic [63:0][TAB_W-1:0] tab;
      logic [63:0] base;
      logic [63:0] cur;
      base = exp_small(64'(1) << 54);
      cur  = ONE60;
      for (int k = 0; k < 64; k++) begin
         tab[k] = to_q47(cur);
         cur    = mul_q60(cur, base);
      end
      return tab;
   endfunction

   // e^-k
   function automatic logic [31:0][TAB_W-1:0] build_far();
      logic [31:0][TAB_W-1:0] tab;
      logic [63:0] base;
      logic [63:0] e1;
      logic [63:0] cur;
      base = exp_small(64'(1) << 54);
      e1   = ONE60;
      for (int k = 0; k < 64; k++) begin
         e1 = mul_q60(e1, base);
      end
      cur = ONE60;
      for (int k = 0; k < 32; k++) begin
         tab[k] = to_q47(cur);
         cur    = mul_q60(cur, e1);
      end
      return tab;
   endfunction

   localparam logic [31:0][TAB_W-1:0] EXP_FAR_TAB  = build_far();
   localparam logic [63:0][TAB_W-1:0] EXP_MID_TAB  = build_mid();
   localparam logic [63:0][TAB_W-1:0] EXP_NEAR_TAB = build_near();

endpackage

>>> rtl/acu_front.sv
// ----------------------------------------------------------------------------
// acu_front
// Table lookup and first product of e^-a, gradient product and rounding.
// ----------------------------------------------------------------------------
module acu_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  acu_pkg::item_type    in_item,
   input  acu_pkg::acti_mode_type mode,
   output logic                 out_valid,
   input  logic                 out_ready,
   output acu_pkg::prod_type    out_data
);
   import acu_pkg::*;

   logic               en1, en2, en3;
   logic               v1_ff, v2_ff, v3_ff;

   tag_type            tag1_ff, tag2_ff;
   logic signed [15:0] d1_ff;
   logic signed [31:0] g1_ff;
   logic [TAB_W-1:0]   t0_1_ff, t1_1_ff, t2_1_ff, t0_2_ff;
   logic [47:0]        hh_ff, hl_ff, lh_ff, ll_ff;
   logic [46:0]        gp2_ff;
   logic               gneg2_ff;
   prod_type           out_ff;

   logic signed [16:0] sx, om, mag;
   logic [16:0]        a_in;
   logic signed [33:0] sig_prod, sq_prod, tanh_g;
   logic signed [31:0] g_in;
   logic [31:0]        gneg_v;
   logic [30:0]        gm;
   logic [15:0]        dn, dm;
   logic [46:0]        gp_in;
   logic [95:0]        sum96;
   logic [47:0]        gr;
   logic [23:0]        pr;
   logic [15:0]        pr_neg;
   logic signed [15:0] gres_in;
   prod_type           out_in;

   assign en3       = !v3_ff || out_ready;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v3_ff;
   assign out_data  = out_ff;

   always_comb begin
      sx       = {in_item.x[15], in_item.x};
      mag      = sx[16] ? -sx : sx;
      a_in     = (mode == MODE_TANH) ? {mag[15:0], 1'b0} : mag;
      om       = FX_ONE - sx;
      sig_prod = om * sx;
      sq_prod  = sx * sx;
      tanh_g   = FX_ONE_SQ - sq_prod;
      case (mode)
         MODE_LINEAR:  g_in = FX_ONE_SQ[31:0];
         MODE_SIGMOID: g_in = sig_prod[31:0];
         MODE_RELU:    g_in = (in_item.x > 16'sd0) ? FX_ONE_SQ[31:0] : 32'sd0;
         MODE_TANH:    g_in = tanh_g[31:0];
         default:      g_in = FX_ONE_SQ[31:0];
      endcase
   end

   always_comb begin
      gneg_v = -g1_ff;
      gm     = g1_ff[31] ? gneg_v[30:0] : g1_ff[30:0];
      dn     = -d1_ff;
      dm     = d1_ff[15] ? dn : d1_ff;
      gp_in  = {16'b0, gm} * {31'b0, dm};
   end

   always_comb begin
      sum96  = {hh_ff, 48'b0} + {24'b0, hl_ff, 24'b0} + {24'b0, lh_ff, 24'b0}
             + {48'b0, ll_ff};
      gr     = {1'b0, gp2_ff} + GRAD_RND;
      pr     = gr[47:GRAD_SHIFT];
      pr_neg = 16'd0 - pr[15:0];
      if (gneg2_ff) begin
         gres_in = (pr >= 24'd32768) ? 16'sh8000 : pr_neg;
      end else begin
         gres_in = (pr > 24'd32767) ? 16'sh7fff : pr[15:0];
      end
      out_in.tag  = tag2_ff;
      out_in.gres = gres_in;
      out_in.t0   = t0_2_ff;
      out_in.p1   = sum96[94:47];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         tag1_ff.grad <= in_item.grad;
         tag1_ff.mode <= mode;
         tag1_ff.x    <= in_item.x;
         tag1_ff.last <= in_item.last;
         d1_ff        <= in_item.d;
         g1_ff        <= g_in;
         t0_1_ff      <= EXP_FAR_TAB[a_in[16:12]];
         t1_1_ff      <= EXP_MID_TAB[a_in[11:6]];
         t2_1_ff      <= EXP_NEAR_TAB[a_in[5:0]];
      end
      if (en2) begin
         tag2_ff  <= tag1_ff;
         t0_2_ff  <= t0_1_ff;
         hh_ff    <= t1_1_ff[47:24] * t2_1_ff[47:24];
         hl_ff    <= t1_1_ff[47:24] * t2_1_ff[23:0];
         lh_ff    <= t1_1_ff[23:0] * t2_1_ff[47:24];
         ll_ff    <= t1_1_ff[23:0] * t2_1_ff[23:0];
         gp2_ff   <= gp_in;
         gneg2_ff <= g1_ff[31] ^ d1_ff[15];
      end
      if (en3) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> rtl/acu_expo.sv
// ----------------------------------------------------------------------------
// acu_expo
// Second product of e^-a and forming of numerator and denominator.
// ----------------------------------------------------------------------------
module acu_expo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  acu_pkg::prod_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output acu_pkg::frac_type out_data
);
   import acu_pkg::*;

   logic               en1, en2;
   logic               v1_ff, v2_ff;
   tag_type            tag1_ff;
   logic signed [15:0] gres1_ff;
   logic [47:0]        hh_ff, hl_ff, lh_ff, ll_ff;
   frac_type           out_ff;

   logic [95:0]        sum96;
   logic [TAB_W-1:0]   e_val;
   frac_type           out_in;

   assign en2       = !v2_ff || out_ready;
   assign en1       = !v1_ff || en2;
   assign in_ready  = en1;
   assign out_valid = v2_ff;
   assign out_data  = out_ff;

   always_comb begin
      sum96 = {hh_ff, 48'b0} + {24'b0, hl_ff, 24'b0} + {24'b0, lh_ff, 24'b0}
            + {48'b0, ll_ff};
      e_val       = sum96[94:47];
      out_in.tag  = tag1_ff;
      out_in.gres = gres1_ff;
      out_in.den  = {1'b0, Q_ONE} + {1'b0, e_val};
      if (tag1_ff.mode == MODE_TANH) begin
         out_in.num = {1'b0, Q_ONE - e_val};
      end else if (tag1_ff.x[15]) begin
         out_in.num = {1'b0, e_val};
      end else begin
         out_in.num = {1'b0, Q_ONE};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         tag1_ff  <= in_data.tag;
         gres1_ff <= in_data.gres;
         hh_ff    <= in_data.t0[47:24] * in_data.p1[47:24];
         hl_ff    <= in_data.t0[47:24] * in_data.p1[23:0];
         lh_ff    <= in_data.t0[23:0] * in_data.p1[47:24];
         ll_ff    <= in_data.t0[23:0] * in_data.p1[23:0];
      end
      if (en2) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> rtl/acu_div.sv
// ----------------------------------------------------------------------------
// acu_div
// Pipelined restoring divider, one quotient bit per stage, and result select.
// ----------------------------------------------------------------------------
module acu_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  acu_pkg::frac_type  in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output logic signed [15:0] out_value,
   output logic               out_last
);
   import acu_pkg::*;

   typedef struct packed {
      tag_type               tag;
      logic signed [15:0]    gres;
      logic [TAB_W:0]        den;
      logic [TAB_W+1:0]      rem;
      logic [DIV_BITS-1:0]   quo;
   } div_type;

   logic                en   [DIV_BITS+1];
   logic                v_ff [DIV_BITS];
   div_type             div_ff [DIV_BITS];
   div_type             div_in [DIV_BITS];
   div_type             start;
   logic                vo_ff;
   logic signed [15:0]  value_ff;
   logic                last_ff;

   div_type             fin;
   logic [DIV_BITS:0]   q_rnd;
   logic [15:0]         mag;
   logic [15:0]         mag_neg;
   logic signed [15:0]  value_in;

   assign in_ready     = en[0];
   assign out_valid    = vo_ff;
   assign out_value    = value_ff;
   assign out_last     = last_ff;

   always_comb begin
      en[DIV_BITS] = !vo_ff || out_ready;
      for (int k = DIV_BITS - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_comb begin
      div_type          src;
      logic             qbit;
      logic [TAB_W+1:0] diff;
      start.tag  = in_data.tag;
      start.gres = in_data.gres;
      start.den  = in_data.den;
      start.rem  = {1'b0, in_data.num};
      start.quo  = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
         src  = (k == 0) ? start : div_ff[(k == 0) ? 0 : k - 1];
         qbit = src.rem >= {1'b0, src.den};
         diff = qbit ? (src.rem - {1'b0, src.den}) : src.rem;
         div_in[k]     = src;
         div_in[k].rem = {diff[TAB_W:0], 1'b0};
         div_in[k].quo = {src.quo[DIV_BITS-2:0], qbit};
      end
   end

   always_comb begin
      fin     = div_ff[DIV_BITS-1];
      q_rnd   = {1'b0, fin.quo} + (DIV_BITS + 1)'(1);
      mag     = 16'(q_rnd[DIV_BITS:1]);
      mag_neg = 16'd0 - mag;
      if (fin.tag.grad) begin
         value_in = fin.gres;
      end else begin
         case (fin.tag.mode)
            MODE_LINEAR:  value_in = fin.tag.x;
            MODE_SIGMOID: value_in = mag;
            MODE_RELU:    value_in = (fin.tag.x > 16'sd0) ? fin.tag.x : 16'sd0;
            MODE_TANH:    value_in = fin.tag.x[15] ? mag_neg : mag;
            default:      value_in = fin.tag.x;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_BITS; k++) begin
            v_ff[k] <= 1'b0;
         end
         vo_ff <= 1'b0;
      end else begin
         for (int k = 0; k < DIV_BITS; k++) begin
            if (en[k]) v_ff[k] <= (k == 0) ? in_valid : v_ff[(k == 0) ? 0 : k - 1];
         end
         if (en[DIV_BITS]) vo_ff <= v_ff[DIV_BITS-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_BITS; k++) begin
         if (en[k]) div_ff[k] <= div_in[k];
      end
      if (en[DIV_BITS]) begin
         value_ff <= value_in;
         last_ff  <= fin.tag.last;
      end
   end

endmodule

>>> rtl/activation_unit.sv
// ----------------------------------------------------------------------------
// activation_unit
// Element-wise activation (linear, sigmoid, ReLU, tanh) and its gradient.
// ----------------------------------------------------------------------------
// Takes one Q4.12 element per clock while the result side does not stall and
// returns one result per element, in order. The depth comes from the
// exponential (three table lookups joined by two split 48-bit products) and
// a 14-stage restoring divider that produces the correctly rounded sigmoid
// and tanh; every element, forward or gradient, travels the same pipeline.
// Each stage holds its request under back-pressure and empty stages fill up,
// so up to 20 requests are in flight. acti_mode is sampled when a request
// is taken.
module activation_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_value [15:0], delta_in [31:16]
   input  logic        req_tuser,   // req_type
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // result_value [15:0]
   output logic        rsp_tlast
);
   import acu_pkg::*;

   acti_mode_type      mode_ff;
   item_type           item;
   logic               f_valid, f_ready;
   prod_type           f_data;
   logic               e_valid, e_ready;
   frac_type           e_data;
   logic signed [15:0] value;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_LINEAR;
      end else if (csr_wr_en) begin
         mode_ff <= acti_mode_type'(csr_wr_data);
      end
   end

   always_comb begin
      item.grad = req_tuser;
      item.x    = req_tdata[15:0];
      item.d    = req_tdata[31:16];
      item.last = req_tlast;
   end

   acu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (item),
      .mode      (mode_ff),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_data  (f_data)
   );

   acu_expo u_expo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (e_valid),
      .out_ready (e_ready),
      .out_data  (e_data)
   );

   acu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid),
      .in_ready  (e_ready),
      .in_data   (e_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (value),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = value;

endmodule

>>> rtl/acu_checker.sv
// ----------------------------------------------------------------------------
// acu_checker
// Port-level checks of the activation unit, bound to the top level.
// ----------------------------------------------------------------------------
module acu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   import acu_pkg::*;

   localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

   logic [CNT_W-1:0] pending_ff;
   logic [CNT_W-1:0] pending_in;
   logic             req_acc, rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (req_acc && !rsp_acc) pending_in = pending_ff + CNT_W'(1);
      if (!req_acc && rsp_acc) pending_in = pending_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with an empty output stage");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_acc |-> pending_ff != '0)
      else $error("response without a pending request");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(PIPE_DEPTH))
      else $error("more requests in flight than pipeline stages");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      pending_ff == '0 |-> !rsp_tvalid)
      else $error("response valid with nothing in flight");

endmodule

bind activation_unit acu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/sv/activation_unit_tb.sv
// ----------------------------------------------------------------------------
// activation_unit_tb
// Self-checking testbench for the element-wise activation unit.
// Streams Q4.12 elements in forward and gradient mode under all four
// activation settings and compares every result with a bit-exact software
// model of sigmoid, tanh, ReLU, linear and their derivatives. Both stream
// sides idle in random bursts; the final part runs at full rate.
// ----------------------------------------------------------------------------
module activation_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import acu_pkg::*;

   localparam logic REQ_FORWARD  = 1'b0;
   localparam logic REQ_GRADIENT = 1'b1;
   localparam int   QF           = 60;
   localparam logic [63:0] Q60_ONE = 64'd1 << QF;
   localparam int   EXP_TERMS    = 27;
   localparam int   STALL_LIMIT  = 2000;
   localparam int   DRAIN_CYCLES = 30;

   typedef struct {
      logic signed [15:0] value;
      logic               last;
   } act_out_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_wr_data = 2'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata   = 32'd0;
   logic        req_tuser   = 1'b0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;

   act_out_type   activation_q[$];
   acti_mode_type mode_now     = MODE_LINEAR;
   bit            idle_on      = 1'b1;
   int            sink_hold    = 0;
   int            idle_cycles  = 0;
   int            mismatches   = 0;
   int            req_count    = 0;
   int            grad_count   = 0;
   int            rsp_count    = 0;

   activation_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      return 64'(prod >> QF);
   endfunction

   // e^-f for f in [0, 1], Q60
   function automatic logic [63:0] exp_unit(input logic [63:0] f);
      logic [63:0] even_sum;
      logic [63:0] odd_sum;
      logic [63:0] term;
      even_sum = Q60_ONE;
      odd_sum  = 64'd0;
      term     = Q60_ONE;
      for (int k = 1; k <= EXP_TERMS; k++) begin
         term = q60_mul(term, f) / 64'(k);
         if (k % 2 == 1) begin
            odd_sum = odd_sum + term;
         end else begin
            even_sum = even_sum + term;
         end
      end
      return even_sum - odd_sum;
   endfunction

   // e^-(a / 2^FRAC_BITS), Q60
   function automatic logic [63:0] exp_neg_fx(input logic [63:0] a);
      logic [63:0] whole;
      logic [63:0] e1;
      logic [63:0] r;
      whole = a >> FRAC_BITS;
      e1    = exp_unit(Q60_ONE);
      r     = exp_unit((a & ((64'd1 << FRAC_BITS) - 64'd1)) << (QF - FRAC_BITS));
      for (int unsigned i = 0; i < whole && r != 64'd0; i++) begin
         r = q60_mul(r, e1);
      end
      return r;
   endfunction

   function automatic logic [63:0] q60_div(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = num / den;
      r = num % den;
      for (int i = 0; i < QF; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] q60_round(input logic [63:0] v);
      return (v + (64'd1 << (QF - 1 - FRAC_BITS))) >> (QF - FRAC_BITS);
   endfunction

   function automatic logic signed [15:0] sigmoid_fx(input logic signed [15:0] x);
      longint      xi;
      logic [63:0] mag;
      logic [63:0] e;
      logic [63:0] v;
      xi  = x;
      mag = (xi < 0) ? -xi : xi;
      e   = exp_neg_fx(mag);
      v   = (xi >= 0) ? q60_div(Q60_ONE, Q60_ONE + e) : q60_div(e, Q60_ONE + e);
      return 16'(q60_round(v));
   endfunction

   function automatic logic signed [15:0] tanh_fx(input logic signed [15:0] x);
      longint      xi;
      longint      m;
      logic [63:0] mag;
      logic [63:0] e;
      xi  = x;
      mag = (xi < 0) ? -xi : xi;
      e   = exp_neg_fx(mag << 1);
      m   = longint'(q60_round(q60_div(Q60_ONE - e, Q60_ONE + e)));
      return 16'((xi < 0) ? -m : m);
   endfunction

   function automatic logic signed [15:0] scaled_delta(input acti_mode_type mode,
                                                       input logic signed [15:0] x,
                                                       input logic signed [15:0] d);
      longint one;
      longint xi;
      longint di;
      longint g;
      longint gm;
      longint dm;
      longint p;
      logic   neg;
      one = longint'(1) << FRAC_BITS;
      xi  = x;
      di  = d;
      case (mode)
         MODE_LINEAR:  g = one * one;
         MODE_SIGMOID: g = (one - xi) * xi;
         MODE_RELU:    g = (xi > 0) ? one * one : 0;
         default:      g = one * one - xi * xi;
      endcase
      neg = (g < 0) != (di < 0);
      gm  = (g < 0) ? -g : g;
      dm  = (di < 0) ? -di : di;
      p   = gm * dm;
      if (p == 0) return 16'sd0;
      p = (p + (longint'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      if (p > 40000) p = 40000;
      if (neg) p = -p;
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return 16'(p);
   endfunction

   function automatic act_out_type compute_activation(input logic grad,
                                                      input acti_mode_type mode,
                                                      input logic signed [15:0] x,
                                                      input logic signed [15:0] d,
                                                      input logic last);
      act_out_type o;
      if (grad == REQ_GRADIENT) begin
         o.value = scaled_delta(mode, x, d);
      end else begin
         case (mode)
            MODE_LINEAR:  o.value = x;
            MODE_SIGMOID: o.value = sigmoid_fx(x);
            MODE_RELU:    o.value = (x > 0) ? x : 16'sd0;
            default:      o.value = tanh_fx(x);
         endcase
      end
      o.last = last;
      return o;
   endfunction

   // result side: random back-pressure bursts
   always @(posedge clock) begin
      if (sink_hold > 0) begin
         sink_hold  <= sink_hold - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         sink_hold  <= $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      act_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (activation_q.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, actual %0d last %0b",
                     $time, $signed(rsp_tdata), rsp_tlast);
         end else begin
            want = activation_q.pop_front();
            if (rsp_tdata !== want.value) begin
               mismatches++;
               $display("%0t: result_value mismatch, expected %0d, actual %0d",
                        $time, want.value, $signed(rsp_tdata));
            end
            if (rsp_tlast !== want.last) begin
               mismatches++;
               $display("%0t: last_out mismatch, expected %0b, actual %0b",
                        $time, want.last, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_element(input logic grad, input logic signed [15:0] x,
                               input logic signed [15:0] d, input logic last);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {d, x};
      req_tuser  <= grad;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      activation_q.push_back(compute_activation(grad, mode_now, x, d, last));
      req_count++;
      if (grad == REQ_GRADIENT) grad_count++;
   endtask

   task automatic set_mode(input acti_mode_type mode);
      req_tvalid <= 1'b0;
      while (activation_q.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      mode_now     = mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_element();
      logic               grad;
      logic signed [15:0] x;
      logic signed [15:0] d;
      int                 sel;
      logic signed [15:0] corners[7];
      corners = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd4096, -16'sd4096, 16'sd1, -16'sd1};
      grad = $urandom_range(0, 1) ? REQ_GRADIENT : REQ_FORWARD;
      sel  = $urandom_range(0, 9);
      if (sel == 0) begin
         x = corners[$urandom_range(0, 6)];
      end else if (sel <= 4) begin
         x = 16'($signed($urandom_range(0, 16384)) - 8192);
      end else begin
         x = 16'($urandom);
      end
      if ($urandom_range(0, 7) == 0) begin
         d = corners[$urandom_range(0, 6)];
      end else begin
         d = 16'($urandom);
      end
      send_element(grad, x, d, $urandom_range(0, 7) == 0);
   endtask

   task automatic test_reset_mode();
      send_element(REQ_FORWARD, -16'sd1234, 16'sd0, 1'b0);
      send_element(REQ_GRADIENT, 16'sd77, -16'sd4096, 1'b1);
   endtask

   task automatic test_forward_corners();
      acti_mode_type modes[4];
      modes = '{MODE_LINEAR, MODE_SIGMOID, MODE_RELU, MODE_TANH};
      foreach (modes[m]) begin
         set_mode(modes[m]);
         send_element(REQ_FORWARD, -16'sd32768, 16'sd32767, 1'b0);
         send_element(REQ_FORWARD, 16'sd32767, -16'sd32768, 1'b0);
         send_element(REQ_FORWARD, 16'sd0, 16'sd0, 1'b0);
         send_element(REQ_FORWARD, -16'sd1, -16'sd1, 1'b1);
      end
   endtask

   task automatic test_gradient_corners();
      set_mode(MODE_LINEAR);
      send_element(REQ_GRADIENT, -16'sd5, 16'sd32767, 1'b0);
      send_element(REQ_GRADIENT, 16'sd0, -16'sd1, 1'b1);
      set_mode(MODE_SIGMOID);
      send_element(REQ_GRADIENT, 16'sd2048, 16'sd32767, 1'b0);
      send_element(REQ_GRADIENT, -16'sd32768, -16'sd32768, 1'b1);
      set_mode(MODE_RELU);
      send_element(REQ_GRADIENT, 16'sd0, 16'sd100, 1'b0);
      send_element(REQ_GRADIENT, 16'sd1, -16'sd32768, 1'b1);
      set_mode(MODE_TANH);
      send_element(REQ_GRADIENT, 16'sd32767, 16'sd32767, 1'b0);
      send_element(REQ_GRADIENT, 16'sd0, -16'sd32768, 1'b1);
   endtask

   task automatic test_random_stream();
      acti_mode_type phases[7];
      phases = '{MODE_LINEAR, MODE_SIGMOID, MODE_RELU, MODE_TANH,
                 acti_mode_type'($urandom_range(0, 3)),
                 acti_mode_type'($urandom_range(0, 3)),
                 acti_mode_type'($urandom_range(0, 3))};
      foreach (phases[p]) begin
         set_mode(phases[p]);
         repeat (90) send_random_element();
      end
   endtask

   task automatic test_full_rate();
      set_mode(MODE_TANH);
      idle_on = 1'b0;
      repeat (40) send_random_element();
      set_mode(MODE_SIGMOID);
      repeat (40) send_random_element();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_mode();
      test_forward_corners();
      test_gradient_corners();
      test_random_stream();
      test_full_rate();
      req_tvalid <= 1'b0;
      while (activation_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests (%0d gradient) over all four activation modes,",
               req_count, grad_count);
      $display("checked %0d results with and without idle bursts on both sides.", rsp_count);
      if (mismatches == 0 && activation_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
